>>> src/lphm_pkg.sv
// ----------------------------------------------------------------------------
// lphm_pkg: shared types and constants for the linear-probing hash table
// Status and action codes, hash and load constants and the transaction record passed front to back.
// ----------------------------------------------------------------------------
package lphm_pkg;

  localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned MIX_SHIFT = 33;
  localparam int unsigned LOAD_NUM = 7;
  localparam int unsigned LOAD_DEN = 10;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_HIT      = 3'd2;
  localparam logic [2:0] ST_MISS     = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic ACT_PUT = 1'b0;
  localparam logic ACT_GET = 1'b1;

  // Hashed transaction handed from the front part to the probe engine.
  // The start slot is kept at full hash width; the back part keeps low bits.
  typedef struct packed {
    logic        action;
    logic [63:0] key;
    logic [63:0] value;
    logic [63:0] hash;
  } lphm_job_t;

endpackage

>>> src/linear_probe_hash_map.sv
// Path: hash pipeline, queue, then the probe engine, which reads and compares
// one slot at a time; a refused put is answered without a slot read.
// The probe engine takes a new transaction only once the last result is handed
// off (accept, read/compare per probed slot, result hand-off).
// Reset: synchronous; afterwards the used marks are swept clear, one slot per
// cycle, before the first transaction is probed.
// ----------------------------------------------------------------------------
// linear_probe_hash_map: open-addressing key/value table, linear probing
// The front hashes each key (fmix64) in a pipeline; a two-entry queue
// decouples it from the probe engine at the back.
// ----------------------------------------------------------------------------
module linear_probe_hash_map #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [63:0] key,
  input  logic [63:0] value_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [63:0] value_out
);
  import lphm_pkg::*;

  lphm_job_t h_job, q_job;
  logic      h_valid, h_stall, q_valid, q_stall;

  // front: hash pipeline
  lphm_hash u_hash (
    .clk, .rst, .in_valid, .in_stall, .action, .key, .value_in,
    .job_valid(h_valid), .job(h_job), .job_stall(h_stall)
  );

  // queue between front and back
  lphm_queue u_queue (
    .clk, .rst, .wr_valid(h_valid), .wr_stall(h_stall), .wr_data(h_job),
    .rd_valid(q_valid), .rd_stall(q_stall), .rd_data(q_job)
  );

  // back: probe engine, load check, slot memories
  lphm_probe #(.TABLE_DEPTH(TABLE_DEPTH)) u_probe (
    .clk, .rst, .job_valid(q_valid), .job_stall(q_stall), .job(q_job),
    .out_valid, .out_stall, .status, .value_out
  );

endmodule

>>> src/lphm_hash.sv
// ----------------------------------------------------------------------------
// lphm_hash: front part, pipelined fmix64 finalizer
// Six stages: xor-shift, partial products, sum and xor-shift, partial
// products, sum, xor-shift. Each 64x64 product keeps its low 64 bits, split
// into three 32x32 partial products over two stages.
// ----------------------------------------------------------------------------
module lphm_hash (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic [63:0]        key,
  input  logic [63:0]        value_in,
  output logic               job_valid,
  output lphm_pkg::lphm_job_t job,
  input  logic               job_stall
);
  import lphm_pkg::*;

  localparam int NST = 6;

  logic [NST-1:0] vld;
  logic           adv;
  logic [63:0]    x0, x1, x3, x4, x5;
  logic [63:0]    pa_ll, pa_x, pb_ll, pb_x;
  lphm_job_t      s [NST];

  // whole pipe moves together; holds when the queue stalls and the last stage is valid
  assign adv      = !job_stall || !vld[NST-1];
  assign in_stall = !adv;

  assign x0 = key ^ (key >> MIX_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 0: first xor-shift
      s[0] <= {action, key, value_in, x0};
      // stage 1: partial products of x * C1
      s[1]  <= s[0];
      pa_ll <= s[0].hash[31:0] * MIX_C1[31:0];
      pa_x  <= {(s[0].hash[31:0] * MIX_C1[63:32]) + (s[0].hash[63:32] * MIX_C1[31:0]),
                32'd0};
      // stage 2: sum and xor-shift
      s[2] <= {s[1].action, s[1].key, s[1].value, x1 ^ (x1 >> MIX_SHIFT)};
      // stage 3: partial products of x * C2
      s[3]  <= s[2];
      pb_ll <= s[2].hash[31:0] * MIX_C2[31:0];
      pb_x  <= {(s[2].hash[31:0] * MIX_C2[63:32]) + (s[2].hash[63:32] * MIX_C2[31:0]),
                32'd0};
      // stage 4: sum
      s[4] <= {s[3].action, s[3].key, s[3].value, x3};
      // stage 5: final xor-shift
      s[5] <= {s[4].action, s[4].key, s[4].value, x4 ^ (x4 >> MIX_SHIFT)};
    end
  end

  assign x1 = pa_ll + pa_x;
  assign x3 = pb_ll + pb_x;
  assign x4 = s[4].hash;
  assign x5 = s[5].hash;

  always_comb begin
    job      = s[NST-1];
    job.hash = x5;
  end
  assign job_valid = vld[NST-1];

endmodule

>>> src/lphm_queue.sv
// ----------------------------------------------------------------------------
// lphm_queue: small FIFO between hash front and probe engine
// Two entries; lets the hash pipe keep moving while a long probe runs.
// ----------------------------------------------------------------------------
module lphm_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_valid,
  output logic               wr_stall,
  input  lphm_pkg::lphm_job_t wr_data,
  output logic               rd_valid,
  input  logic               rd_stall,
  output lphm_pkg::lphm_job_t rd_data
);
  import lphm_pkg::*;

  lphm_job_t mem [2];
  logic      wp, rp;
  logic [1:0] cnt;
  logic      wr_en, rd_en;

  assign wr_stall = (cnt == 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign wr_en    = wr_valid && !wr_stall;
  assign rd_en    = rd_valid && !rd_stall;
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr_en) wp <= !wp;
      if (rd_en) rp <= !rp;
      cnt <= cnt + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wr_data;
  end

endmodule

>>> src/lphm_probe.sv
// ----------------------------------------------------------------------------
// lphm_probe: back part, linear-probe engine over the slot memories
// Each slot is read (address, registered data), then compared.
// Used marks live in a memory cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module lphm_probe #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_stall,
  input  lphm_pkg::lphm_job_t job,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [63:0]        value_out
);
  import lphm_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = CW + 4;
  localparam logic [LW-1:0] LOAD_LIM = LW'(TABLE_DEPTH * LOAD_NUM);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_CHECK, S_DONE} state_t;

  state_t       state;
  logic         used_mem [TABLE_DEPTH];
  logic [63:0]  key_mem  [TABLE_DEPTH];
  logic [63:0]  val_mem  [TABLE_DEPTH];
  logic         rd_used;
  logic [63:0]  rd_key, rd_val;
  logic [AW-1:0] addr;
  logic [CW-1:0] steps;
  logic [CW-1:0] entry_count;
  lphm_job_t    cur;
  logic         wr_en;
  logic [AW-1:0] wr_addr;
  logic [63:0]  wr_val;
  logic         full_load;

  assign full_load = ({4'd0, entry_count} * LW'(LOAD_DEN)) >= LOAD_LIM;
  assign job_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    rd_used <= used_mem[addr];
    rd_key  <= key_mem[addr];
    rd_val  <= val_mem[addr];
    if (state == S_CLEAR) used_mem[addr] <= 1'b0;
    else if (wr_en) used_mem[wr_addr] <= 1'b1;
    if (wr_en) begin
      key_mem[wr_addr] <= cur.key;
      val_mem[wr_addr] <= wr_val;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr;
    wr_val  = cur.value;
    if (state == S_CHECK && cur.action == ACT_PUT &&
        (!rd_used || rd_key == cur.key)) wr_en = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      addr        <= '0;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          addr <= addr + 1'b1;
          if (addr == AW'(TABLE_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (job_valid) begin
            cur   <= job;
            addr  <= job.hash[AW-1:0];
            steps <= '0;
            if (job.action == ACT_PUT && full_load) begin
              status    <= ST_FULL;
              value_out <= '0;
              out_valid <= 1'b1;
              state     <= S_DONE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (!rd_used) begin
            status    <= (cur.action == ACT_PUT) ? ST_INSERTED : ST_MISS;
            value_out <= '0;
            out_valid <= 1'b1;
            state     <= S_DONE;
            if (cur.action == ACT_PUT) entry_count <= entry_count + 1'b1;
          end else if (rd_key == cur.key) begin
            status    <= (cur.action == ACT_PUT) ? ST_UPDATED : ST_HIT;
            value_out <= (cur.action == ACT_GET) ? rd_val : 64'd0;
            out_valid <= 1'b1;
            state     <= S_DONE;
          end else if (steps == CW'(TABLE_DEPTH - 1)) begin
            status    <= (cur.action == ACT_PUT) ? ST_FULL : ST_MISS;
            value_out <= '0;
            out_valid <= 1'b1;
            state     <= S_DONE;
          end else begin
            addr  <= (addr == AW'(TABLE_DEPTH - 1)) ? '0 : addr + 1'b1;
            steps <= steps + 1'b1;
            state <= S_READ;
          end
        end
        S_DONE: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/lphm_check.sv
// ----------------------------------------------------------------------------
// lphm_check: port-level assertions for the hash table
// Checks result codes, a zero value_out without a hit, and the output handshake.
// ----------------------------------------------------------------------------
module lphm_check (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [63:0] value_out
);
  import lphm_pkg::*;

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_FULL) else $error("bad status code");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_HIT) |-> value_out == 64'd0)
    else $error("value_out nonzero without hit");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(status) && $stable(value_out))
    else $error("stalled result changed");

endmodule

bind linear_probe_hash_map lphm_check u_check (
  .clk, .rst, .out_valid, .out_stall, .status, .value_out
);
